// ===== rtl/fbgi_pkg.sv =====
// Package for the font block glyph index core.
// Holds widths, action codes and the range check result type.
// No dependencies.
package fbgi_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = 5;
    localparam int CODE_W     = 16;
    localparam int SIZE_W     = CODE_W + 1;
    localparam int BLKNUM_W   = 4;
    localparam int GLYPH_W    = 20;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Result of checking one code against one range entry
    typedef struct packed {
        logic              hit;     // start <= code <= end
        logic [SIZE_W-1:0] size;    // end - start + 1, zero when reversed
        logic [CODE_W-1:0] offset;  // code - start
    } range_res_t;

endpackage

// ===== rtl/font_block_glyph_index_core.sv =====
// Top level of the font block glyph index core: range table, scan sequencer,
// output register. Depends on fbgi_pkg and fbgi_range_unit.
//
//  channel | direction | handshake          | moves
//  --------+-----------+--------------------+-------------------------------------
//  in      | input     | in_valid/in_stall  | write or lookup request
//  out     | output    | out_valid/out_stall| found, block_number, glyph_index
//  cfg     | input     | cfg_valid/cfg_ready| block_count register value
//
// A write request gives no result. A lookup request scans the table from
// entry 0 up to the first matching entry, or up to block_count capped at
// MAX_BLOCKS when none matches (an empty table ends it at once): one table
// entry goes through the shared range unit per cycle, with the next entry
// prefetched from the table read port.
// Reset clears the sequencer, block_count and the output valid; the range
// table holds garbage until written. A stalled result holds the scan on its
// final entry until the output register frees up.
module font_block_glyph_index_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          action,
    input  logic [3:0]                    entry_index,
    input  logic [fbgi_pkg::CODE_W-1:0]   range_start,
    input  logic [fbgi_pkg::CODE_W-1:0]   range_end,
    input  logic [fbgi_pkg::CODE_W-1:0]   char_code,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          found,
    output logic [fbgi_pkg::BLKNUM_W-1:0] block_number,
    output logic [fbgi_pkg::GLYPH_W-1:0]  glyph_index,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fbgi_pkg::CNT_W-1:0]    cfg_data
);
    import fbgi_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Range table, one read port with registered data
    logic [CODE_W-1:0] start_mem [MAX_BLOCKS];
    logic [CODE_W-1:0] end_mem   [MAX_BLOCKS];
    logic [CODE_W-1:0] rd_start_reg;
    logic [CODE_W-1:0] rd_end_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_en;

    logic [CNT_W-1:0]   block_count_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   count_sat;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [GLYPH_W-1:0] base_reg, base_next;
    logic [CODE_W-1:0]  code_reg, code_next;

    logic               out_valid_reg;
    logic               out_found_reg;
    logic [BLKNUM_W-1:0] out_block_reg;
    logic [GLYPH_W-1:0] out_glyph_reg;

    logic               in_accept;
    logic               wr_en;
    logic               lookup_start;
    logic               out_free;
    logic               last_entry;
    logic               hit_valid;
    logic               finish;
    range_res_t         rres;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign wr_en        = in_accept && (action == ACT_WRITE);
    assign lookup_start = in_accept && (action == ACT_LOOKUP);

    // Config must only arrive while idle; the block itself does not enforce this, and it is always taken
    assign cfg_ready = 1'b1;

    assign out_free  = !out_valid_reg || !out_stall;
    assign count_sat = (block_count_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                              : block_count_reg;

    fbgi_range_unit u_range (
        .code (code_reg),
        .lo   (rd_start_reg),
        .hi   (rd_end_reg),
        .res  (rres)
    );

    // An empty table ends the scan at once with no match
    assign last_entry = (count_reg == '0) ||
                        (count_reg == ({1'b0, idx_reg} + CNT_W'(1)));
    assign hit_valid  = rres.hit && (count_reg != '0);
    assign finish     = (state_reg == ST_SCAN) && (hit_valid || last_entry) && out_free;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        base_next  = base_reg;
        code_next  = code_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (lookup_start)
                begin
                    state_next = ST_SCAN;
                    count_next = count_sat;
                    idx_next   = '0;
                    base_next  = '0;
                    code_next  = char_code;
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                end
            end
            ST_SCAN:
            begin
                if (hit_valid || last_entry)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // Accumulate this entry's size, prefetch the next one
                    idx_next  = idx_reg + IDX_W'(1);
                    base_next = base_reg + GLYPH_W'(rres.size);
                    rd_en     = 1'b1;
                    rd_addr   = idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            block_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                block_count_reg <= cfg_data;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        idx_reg   <= idx_next;
        base_reg  <= base_next;
        code_reg  <= code_next;
        if (finish)
        begin
            out_found_reg <= hit_valid;
            out_block_reg <= hit_valid ? BLKNUM_W'(idx_reg) : '0;
            out_glyph_reg <= hit_valid ? (base_reg + GLYPH_W'(rres.offset)) : '0;
        end
    end

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[entry_index[IDX_W-1:0]] <= range_start;
            end_mem[entry_index[IDX_W-1:0]]   <= range_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_start_reg <= start_mem[rd_addr];
            rd_end_reg   <= end_mem[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = out_found_reg;
    assign block_number = out_block_reg;
    assign glyph_index  = out_glyph_reg;

endmodule

// ===== rtl/fbgi_range_unit.sv =====
// Shared range check unit: compares a code against one table entry.
// Gives hit, entry size and offset of the code inside the entry.
// Depends on fbgi_pkg.
module fbgi_range_unit (
    input  logic [fbgi_pkg::CODE_W-1:0] code,
    input  logic [fbgi_pkg::CODE_W-1:0] lo,
    input  logic [fbgi_pkg::CODE_W-1:0] hi,
    output fbgi_pkg::range_res_t        res
);
    import fbgi_pkg::*;

    logic ge_lo;
    logic le_hi;
    logic reversed;

    assign ge_lo    = (code >= lo);
    assign le_hi    = (code <= hi);
    assign reversed = (hi < lo);

    always_comb
    begin
        res.hit    = ge_lo && le_hi;
        res.offset = code - lo;
        if (reversed)
        begin
            res.size = '0;
        end
        else
        begin
            res.size = {1'b0, hi} - {1'b0, lo} + SIZE_W'(1);
        end
    end

endmodule
